// ===== rtl/lzhc_pkg.sv =====
// ============================================================================
// lzhc_pkg
// Shared types and constants for the lzop header checker.
// ============================================================================
package lzhc_pkg;

    // Verdict codes carried in the status field
    localparam logic [3:0] STAT_BUSY     = 4'd0;
    localparam logic [3:0] STAT_OK       = 4'd1;
    localparam logic [3:0] STAT_MAGIC    = 4'd2;
    localparam logic [3:0] STAT_VERSION  = 4'd3;
    localparam logic [3:0] STAT_LIBRARY  = 4'd4;
    localparam logic [3:0] STAT_NEEDED   = 4'd5;
    localparam logic [3:0] STAT_METHOD   = 4'd6;
    localparam logic [3:0] STAT_FLAGS    = 4'd7;
    localparam logic [3:0] STAT_CHECKSUM = 4'd8;

    // Block checksum kinds
    localparam logic [1:0] CHK_NONE  = 2'd0;
    localparam logic [1:0] CHK_CRC   = 2'd1;
    localparam logic [1:0] CHK_ADLER = 2'd2;

    localparam logic [15:0] VERSION_MAX = 16'h1030;
    localparam logic [15:0] LIB_MIN     = 16'h0100;

    localparam logic [31:0] FLG_H_CRC32   = 32'h0000_1000;
    localparam logic [31:0] FLG_MASK      = 32'h0000_3FFF;
    localparam logic [31:0] FLG_OS_MASK   = 32'hFF00_0000;
    localparam logic [31:0] FLG_CS_MASK   = 32'h00F0_0000;
    localparam logic [31:0] FLG_MULTIPART = 32'h0000_0400;
    localparam logic [31:0] FLG_H_FILTER  = 32'h0000_0800;
    localparam logic [31:0] FLG_EXTRA     = 32'h0000_0040;
    localparam logic [31:0] FLG_CRC32_C   = 32'h0000_0200;
    localparam logic [31:0] FLG_ADLER32_C = 32'h0000_0002;
    localparam logic [31:0] FLG_CRC32_D   = 32'h0000_0100;
    localparam logic [31:0] FLG_ADLER32_D = 32'h0000_0001;
    localparam logic [31:0] FLG_BAD =
        ~(FLG_MASK | FLG_OS_MASK | FLG_CS_MASK) | FLG_MULTIPART | FLG_H_FILTER;

    localparam int MAGIC_LEN = 9;

    typedef enum logic [13:0] {
        PH_MAGIC   = 14'b00000000000001,
        PH_VER     = 14'b00000000000010,
        PH_LIB     = 14'b00000000000100,
        PH_NEED    = 14'b00000000001000,
        PH_METHOD  = 14'b00000000010000,
        PH_LEVEL   = 14'b00000000100000,
        PH_FLAGS   = 14'b00000001000000,
        PH_MODE    = 14'b00000010000000,
        PH_NAMELEN = 14'b00000100000000,
        PH_NAME    = 14'b00001000000000,
        PH_HCHK    = 14'b00010000000000,
        PH_XLEN    = 14'b00100000000000,
        PH_XSKIP   = 14'b01000000000000,
        PH_DONE    = 14'b10000000000000
    } t_phase;

    // One result transaction
    typedef struct packed {
        logic [7:0]  method;
        logic [1:0]  data_check;
        logic [1:0]  packed_check;
        logic [32:0] hdr_bytes;
        logic [3:0]  status;
    } t_result;

endpackage

// ===== rtl/lzhc_sum.sv =====
// ============================================================================
// lzhc_sum
// Running CRC-32 and Adler-32 over the checksummed header bytes.
// ============================================================================
module lzhc_sum
    import lzhc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clear,
    input  logic        i_update,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc_sum,
    output logic [31:0] o_adler_sum
);

    localparam logic [16:0] ADLER_MOD = 17'd65521;

    logic [31:0] r_crc, n_crc;
    logic [15:0] r_lo, n_lo;
    logic [15:0] r_hi, n_hi;
    logic [16:0] w_lo_sum;
    logic [16:0] w_hi_sum;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
        end
        return c;
    endfunction

    // both sums stay below the modulus, so one subtract corrects each step
    always_comb begin
        w_lo_sum = {1'b0, r_lo} + {9'd0, i_byte};
        n_lo     = (w_lo_sum >= ADLER_MOD) ? 16'(w_lo_sum - ADLER_MOD) : w_lo_sum[15:0];
        w_hi_sum = {1'b0, r_hi} + {1'b0, n_lo};
        n_hi     = (w_hi_sum >= ADLER_MOD) ? 16'(w_hi_sum - ADLER_MOD) : w_hi_sum[15:0];
        n_crc    = crc_byte(r_crc, i_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_crc <= 32'hFFFF_FFFF;
            r_lo  <= 16'd1;
            r_hi  <= 16'd0;
        end else if (i_update) begin
            r_crc <= n_crc;
            r_lo  <= n_lo;
            r_hi  <= n_hi;
        end
    end

    assign o_crc_sum   = ~r_crc;
    assign o_adler_sum = {r_hi, r_lo};

endmodule

// ===== rtl/lzhc_parse.sv =====
// ============================================================================
// lzhc_parse
// Header field sequencer: field checks, skips, verdict and reported values.
// ============================================================================
module lzhc_parse
    import lzhc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_advance,
    input  logic [7:0]  i_byte,
    input  logic        i_start,
    input  logic [31:0] i_crc_sum,
    input  logic [31:0] i_adler_sum,
    output logic        o_sum_upd,
    output t_result     o_result
);

    t_phase      r_phase, c_phase, n_phase;
    logic [3:0]  r_pos, c_pos, n_pos;
    logic [31:0] r_shift, c_shift, n_shift;
    logic [31:0] r_flags, c_flags, n_flags;
    logic [7:0]  r_name, c_name, n_name;
    logic [32:0] r_skip, c_skip, n_skip;
    logic [32:0] r_count, c_count, n_count;
    logic [3:0]  r_final, c_final, n_final;
    logic [7:0]  r_method, c_method, n_method;

    logic [31:0] w_cat;
    logic [3:0]  w_pos_inc;
    logic [7:0]  w_name_dec;
    logic [32:0] w_skip_dec;
    logic [31:0] w_hsum;
    logic        w_acc;

    function automatic logic [7:0] magic_byte(input logic [3:0] pos);
        case (pos)
            4'd0:    return 8'h89;
            4'd1:    return 8'h4C;
            4'd2:    return 8'h5A;
            4'd3:    return 8'h4F;
            4'd4:    return 8'h00;
            4'd5:    return 8'h0D;
            4'd6:    return 8'h0A;
            4'd7:    return 8'h1A;
            4'd8:    return 8'h0A;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [3:0] field_len(input t_phase ph);
        case (ph)
            PH_VER, PH_LIB, PH_NEED:    return 4'd2;
            PH_FLAGS, PH_HCHK, PH_XLEN: return 4'd4;
            PH_MODE:                    return 4'd12;
            default:                    return 4'd1;
        endcase
    endfunction

    function automatic logic [1:0] check_kind(input logic [31:0] flags,
                                              input logic [31:0] crc_bit,
                                              input logic [31:0] adler_bit);
        if ((flags & crc_bit) != 32'd0) return CHK_CRC;
        if ((flags & adler_bit) != 32'd0) return CHK_ADLER;
        return CHK_NONE;
    endfunction

    always_comb begin
        // start restarts from the reset state with this byte as magic byte 0
        c_phase  = i_start ? PH_MAGIC  : r_phase;
        c_pos    = i_start ? 4'd0      : r_pos;
        c_shift  = i_start ? 32'd0     : r_shift;
        c_flags  = i_start ? 32'd0     : r_flags;
        c_name   = i_start ? 8'd0      : r_name;
        c_skip   = i_start ? 33'd0     : r_skip;
        c_count  = i_start ? 33'd0     : r_count;
        c_final  = i_start ? STAT_BUSY : r_final;
        c_method = i_start ? 8'd0      : r_method;

        n_phase  = c_phase;
        n_pos    = c_pos;
        n_shift  = c_shift;
        n_flags  = c_flags;
        n_name   = c_name;
        n_skip   = c_skip;
        n_count  = c_count;
        n_final  = c_final;
        n_method = c_method;

        w_cat      = {c_shift[23:0], i_byte};
        w_pos_inc  = c_pos + 4'd1;
        w_name_dec = (c_name != 8'd0) ? c_name - 8'd1 : c_name;
        w_skip_dec = (c_skip != 33'd0) ? c_skip - 33'd1 : c_skip;
        w_hsum     = ((c_flags & FLG_H_CRC32) != 32'd0) ? i_crc_sum : i_adler_sum;

        if (c_final == STAT_BUSY) begin
            n_count = c_count + 33'd1;
            case (c_phase)
                PH_MAGIC: begin
                    if (c_pos >= 4'(MAGIC_LEN) || i_byte != magic_byte(c_pos)) begin
                        n_final = STAT_MAGIC;
                        n_phase = PH_DONE;
                    end else if (w_pos_inc == 4'(MAGIC_LEN)) begin
                        n_phase = PH_VER;
                        n_pos   = 4'd0;
                        n_shift = 32'd0;
                    end else begin
                        n_pos = w_pos_inc;
                    end
                end
                PH_NAME: begin
                    n_name = w_name_dec;
                    if (w_name_dec == 8'd0) begin
                        n_phase = PH_HCHK;
                        n_pos   = 4'd0;
                        n_shift = 32'd0;
                    end
                end
                PH_XSKIP: begin
                    n_skip = w_skip_dec;
                    if (w_skip_dec == 33'd0) begin
                        n_final = STAT_OK;
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE: begin
                    n_phase = c_phase;
                end
                default: begin
                    // fixed-length big-endian fields, single-byte ones included
                    n_shift = w_cat;
                    n_pos   = w_pos_inc;
                    if (w_pos_inc >= field_len(c_phase)) begin
                        n_pos   = 4'd0;
                        n_shift = 32'd0;
                        case (c_phase)
                            PH_VER: begin
                                if (w_cat[15:0] > VERSION_MAX || w_cat[31:16] != 16'd0) begin
                                    n_final = STAT_VERSION;
                                    n_phase = PH_DONE;
                                end else begin
                                    n_phase = PH_LIB;
                                end
                            end
                            PH_LIB: begin
                                if (w_cat[15:0] < LIB_MIN && w_cat[31:16] == 16'd0) begin
                                    n_final = STAT_LIBRARY;
                                    n_phase = PH_DONE;
                                end else begin
                                    n_phase = PH_NEED;
                                end
                            end
                            PH_NEED: begin
                                if (w_cat[15:0] > VERSION_MAX || w_cat[31:16] != 16'd0) begin
                                    n_final = STAT_NEEDED;
                                    n_phase = PH_DONE;
                                end else begin
                                    n_phase = PH_METHOD;
                                end
                            end
                            PH_METHOD: begin
                                n_method = i_byte;
                                if (i_byte < 8'd1 || i_byte > 8'd3) begin
                                    n_final = STAT_METHOD;
                                    n_phase = PH_DONE;
                                end else begin
                                    n_phase = PH_LEVEL;
                                end
                            end
                            PH_LEVEL: begin
                                n_phase = PH_FLAGS;
                            end
                            PH_FLAGS: begin
                                n_flags = w_cat;
                                if ((w_cat & FLG_BAD) != 32'd0) begin
                                    n_final = STAT_FLAGS;
                                    n_phase = PH_DONE;
                                end else begin
                                    n_phase = PH_MODE;
                                end
                            end
                            PH_MODE: begin
                                n_phase = PH_NAMELEN;
                            end
                            PH_NAMELEN: begin
                                n_name  = i_byte;
                                n_phase = (i_byte != 8'd0) ? PH_NAME : PH_HCHK;
                            end
                            PH_HCHK: begin
                                if (w_hsum != w_cat) begin
                                    n_final = STAT_CHECKSUM;
                                    n_phase = PH_DONE;
                                end else if ((c_flags & FLG_EXTRA) != 32'd0) begin
                                    n_phase = PH_XLEN;
                                end else begin
                                    n_final = STAT_OK;
                                    n_phase = PH_DONE;
                                end
                            end
                            PH_XLEN: begin
                                n_skip  = {1'b0, w_cat} + 33'd4;
                                n_phase = PH_XSKIP;
                            end
                            default: begin
                                n_phase = c_phase;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // checksum covers version field through the filename
    assign o_sum_upd = (c_final == STAT_BUSY) &&
                       (c_phase == PH_VER || c_phase == PH_LIB || c_phase == PH_NEED ||
                        c_phase == PH_METHOD || c_phase == PH_LEVEL ||
                        c_phase == PH_FLAGS || c_phase == PH_MODE ||
                        c_phase == PH_NAMELEN || c_phase == PH_NAME);

    assign w_acc = (n_final == STAT_OK);

    always_comb begin
        o_result.status       = n_final;
        o_result.hdr_bytes    = w_acc ? n_count : 33'd0;
        o_result.packed_check = w_acc ? check_kind(n_flags, FLG_CRC32_C, FLG_ADLER32_C)
                                      : CHK_NONE;
        o_result.data_check   = w_acc ? check_kind(n_flags, FLG_CRC32_D, FLG_ADLER32_D)
                                      : CHK_NONE;
        o_result.method       = n_method;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC;
            r_pos    <= 4'd0;
            r_shift  <= 32'd0;
            r_flags  <= 32'd0;
            r_name   <= 8'd0;
            r_skip   <= 33'd0;
            r_count  <= 33'd0;
            r_final  <= STAT_BUSY;
            r_method <= 8'd0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_shift  <= n_shift;
            r_flags  <= n_flags;
            r_name   <= n_name;
            r_skip   <= n_skip;
            r_count  <= n_count;
            r_final  <= n_final;
            r_method <= n_method;
        end
    end

endmodule

// ===== rtl/lzhc_unit.sv =====
// ============================================================================
// lzop_header_checker_unit
// Streaming lzop file header checker, one header byte per transaction.
// ============================================================================
// Pipeline: a byte waits in the input register until the result register
//   is free or draining, and then loads into it.
// Throughput: one byte per cycle unless the master side stalls, set by
//   the single pass through the field sequencer and the CRC/Adler byte
//   step between the two registers.
// Reset: synchronous, active low; the checker starts in the magic phase, so
//   bytes are parsed from the first transaction even without a start flag.
// ============================================================================
module lzop_header_checker_unit
    import lzhc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: one header byte per transaction
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] byte_req
    input  logic        i_s_tuser,   // [0] start_req
    // master side: one result per accepted byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata    // [3:0] status, [36:4] hdr_bytes,
                                     // [38:37] packed_check_type,
                                     // [40:39] data_check_type,
                                     // [48:41] method, [55:49] zero
);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_start;

    // result register
    logic        r_out_valid;
    t_result     r_out;

    logic        w_advance;
    logic        w_sum_upd;
    logic [31:0] w_crc_sum;
    logic [31:0] w_adler_sum;
    t_result     w_result;

    // the held byte moves on whenever the result register is free or draining
    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte  <= i_s_tdata;
            r_in_start <= i_s_tuser;
        end
    end

    lzhc_sum u_sum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (w_advance && r_in_start),
        .i_update    (w_advance && w_sum_upd),
        .i_byte      (r_in_byte),
        .o_crc_sum   (w_crc_sum),
        .o_adler_sum (w_adler_sum)
    );

    lzhc_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_byte      (r_in_byte),
        .i_start     (r_in_start),
        .i_crc_sum   (w_crc_sum),
        .i_adler_sum (w_adler_sum),
        .o_sum_upd   (w_sum_upd),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out};

endmodule
